/* hdl/pbub_pkg.sv */
package pbub_pkg;

  localparam int NUM_CAMERAS_DEF = 4;

  // reset values of the configuration registers
  localparam logic [15:0] PRINCIPAL_X_RST = 16'd5063;
  localparam logic [15:0] PRINCIPAL_Y_RST = 16'd3879;
  localparam logic [23:0] INV_FOCAL_X_RST = 24'd44522;
  localparam logic [23:0] INV_FOCAL_Y_RST = 24'd44455;

  // configuration register indexes
  localparam logic [1:0] CFG_PRINCIPAL_X = 2'd0;
  localparam logic [1:0] CFG_PRINCIPAL_Y = 2'd1;
  localparam logic [1:0] CFG_INV_FOCAL_X = 2'd2;
  localparam logic [1:0] CFG_INV_FOCAL_Y = 2'd3;

  // func codes
  localparam logic FUNC_ROW_WRITE = 1'b0;
  localparam logic FUNC_BEARING   = 1'b1;

  localparam logic [1:0] ROW_NONE = 2'd3;
  localparam logic [7:0] CLASS_TARGET = 8'd0;

  // datapath widths
  localparam int MAG_W  = 59;  // |w|, w held exactly
  localparam int NRM_W  = 30;  // normalized magnitude, top one at bit 29
  localparam int SQ_W   = 62;  // sum of three squares
  localparam int ROOT_W = 31;  // floor(sqrt) of SQ_W bits
  localparam int REM_W  = ROOT_W + 3;
  localparam int Q_W    = 15;  // quotient never exceeds 2^14 + 1
  localparam int NUM_W  = NRM_W + 15;  // m*2^14 + n/2 can carry past bit 43
  localparam logic [5:0] NRM_LEN = 6'd30;
  localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

  typedef struct packed {
    logic        func;
    logic [1:0]  camera;
    logic [1:0]  row_index;
    logic [47:0] row_coeffs;
    logic [15:0] box_x1;
    logic [15:0] box_y1;
    logic [15:0] box_x2;
    logic [15:0] box_y2;
    logic [7:0]  class_id;
  } box_t;

  typedef struct packed {
    logic signed [15:0] bearing_x;
    logic signed [15:0] bearing_y;
    logic signed [15:0] bearing_z;
    logic [1:0]         source_camera;
  } bearing_t;

  typedef struct packed {
    logic [15:0] principal_x;
    logic [15:0] principal_y;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
  } cfg_t;

  // passenger data carried alongside sqrt and divide
  typedef struct packed {
    logic [1:0]             cam;
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][NRM_W-1:0]  mag;
  } carry_t;

endpackage

/* hdl/pbub_front.sv */
module pbub_front #(
  parameter int NUM_CAMERAS = pbub_pkg::NUM_CAMERAS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     accept,
  input  pbub_pkg::box_t           box,
  input  pbub_pkg::cfg_t           cfg,
  output logic                     sum_valid,
  output logic [pbub_pkg::SQ_W-1:0] sum,
  output pbub_pkg::carry_t         carry
);

  localparam int IDX_W = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;

  // rotation rows, one bank per matrix row
  logic [47:0] rot [3][NUM_CAMERAS];

  logic [4:0]       cam_ext;
  logic [IDX_W-1:0] cam_idx;
  logic             cam_ok;
  assign cam_ext = {3'b000, box.camera};
  assign cam_idx = cam_ext[IDX_W-1:0];
  assign cam_ok  = cam_ext < 5'(NUM_CAMERAS);

  always_ff @(posedge clk) begin
    if (accept && box.func == pbub_pkg::FUNC_ROW_WRITE && cam_ok &&
        box.row_index != pbub_pkg::ROW_NONE) begin
      rot[box.row_index][cam_idx] <= box.row_coeffs;
    end
  end

  // s1: centre offsets, row read
  logic [7:0] v;
  logic signed [17:0] du1, dv1;
  logic [2:0][47:0]   r1, r2;
  logic [1:0]         cam1, cam2, cam3, cam4, cam5, cam6, cam7, cam8;
  logic signed [41:0] u2, vv2;
  logic signed [59:0] p3 [3][3];
  logic [2:0][pbub_pkg::MAG_W-1:0] mag4, mag5;
  logic [2:0] neg4, neg5, neg6, neg7, neg8;
  logic [5:0] len5;
  logic [2:0][pbub_pkg::NRM_W-1:0] nm6, nm7, nm8;
  logic zero6, zero7, zero8;
  logic [2:0][59:0] sq7;
  logic [pbub_pkg::SQ_W-1:0] sum8;

  logic signed [17:0] du_next, dv_next;
  logic [2:0][47:0]   r_next;
  logic signed [41:0] fx_ext, fy_ext, du_ext, dv_ext;
  logic signed [59:0] p_next [3][3];
  logic [2:0][pbub_pkg::MAG_W-1:0] mag_next;
  logic [2:0] neg_next;
  logic [pbub_pkg::MAG_W-1:0] orv;
  logic [5:0] len_next;
  logic [2:0][pbub_pkg::NRM_W-1:0] nm_next;

  always_comb begin
    du_next = 18'($signed({2'b00, box.box_x1}) + $signed({2'b00, box.box_x2}))
              - $signed({1'b0, cfg.principal_x, 1'b0});
    dv_next = 18'($signed({2'b00, box.box_y1}) + $signed({2'b00, box.box_y2}))
              - $signed({1'b0, cfg.principal_y, 1'b0});
    for (int i = 0; i < 3; i++) begin
      r_next[i] = cam_ok ? rot[i][cam_idx] : 48'd0;
    end
  end

  assign du_ext = 42'(du1);
  assign dv_ext = 42'(dv1);
  assign fx_ext = $signed({18'd0, cfg.inv_focal_x});
  assign fy_ext = $signed({18'd0, cfg.inv_focal_y});

  // s3 products, s4 sums
  always_comb begin
    logic signed [59:0] c0, c1, c2, ue, ve, w;
    for (int i = 0; i < 3; i++) begin
      c0 = 60'($signed(r2[i][15:0]));
      c1 = 60'($signed(r2[i][31:16]));
      c2 = 60'($signed(r2[i][47:32]));
      ue = 60'(u2);
      ve = 60'(vv2);
      p_next[i][0] = c0 * ue;
      p_next[i][1] = c1 * ve;
      p_next[i][2] = c2 <<< 29;
    end
    for (int i = 0; i < 3; i++) begin
      w = p3[i][0] + p3[i][1] + p3[i][2];
      neg_next[i] = w[59];
      mag_next[i] = w[59] ? pbub_pkg::MAG_W'(-w) : pbub_pkg::MAG_W'(w);
    end
  end

  // s5 leading-one position of the largest magnitude
  always_comb begin
    orv = mag4[0] | mag4[1] | mag4[2];
    len_next = 6'd0;
    for (int b = 0; b < pbub_pkg::MAG_W; b++) begin
      if (orv[b]) len_next = 6'(b + 1);
    end
  end

  // s6 common shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (len5 > pbub_pkg::NRM_LEN) begin
        nm_next[i] = pbub_pkg::NRM_W'(mag5[i] >> (len5 - pbub_pkg::NRM_LEN));
      end else begin
        nm_next[i] = pbub_pkg::NRM_W'(mag5[i] << (pbub_pkg::NRM_LEN - len5));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[6:0], accept && box.func == pbub_pkg::FUNC_BEARING &&
            box.class_id == pbub_pkg::CLASS_TARGET};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      du1  <= du_next;
      dv1  <= dv_next;
      r1   <= r_next;
      cam1 <= box.camera;
      u2   <= du_ext * fx_ext;
      vv2  <= dv_ext * fy_ext;
      r2   <= r1;
      cam2 <= cam1;
      p3   <= p_next;
      cam3 <= cam2;
      mag4 <= mag_next;
      neg4 <= neg_next;
      cam4 <= cam3;
      mag5 <= mag4;
      neg5 <= neg4;
      len5 <= len_next;
      cam5 <= cam4;
      nm6  <= nm_next;
      neg6 <= neg5;
      zero6 <= len5 == 6'd0;
      cam6 <= cam5;
      for (int i = 0; i < 3; i++) begin
        sq7[i] <= 60'(nm6[i]) * 60'(nm6[i]);
      end
      nm7  <= nm6;
      neg7 <= neg6;
      zero7 <= zero6;
      cam7 <= cam6;
      sum8 <= pbub_pkg::SQ_W'(sq7[0]) + pbub_pkg::SQ_W'(sq7[1])
              + pbub_pkg::SQ_W'(sq7[2]);
      nm8  <= nm7;
      neg8 <= neg7;
      zero8 <= zero7;
      cam8 <= cam7;
    end
  end

  assign sum_valid  = v[7];
  assign sum        = sum8;
  assign carry.cam  = cam8;
  assign carry.zero = zero8;
  assign carry.neg  = neg8;
  assign carry.mag  = nm8;

endmodule

/* hdl/pbub_isqrt.sv */
module pbub_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [pbub_pkg::SQ_W-1:0]   rad,
  input  pbub_pkg::carry_t            in_carry,
  output logic                        out_valid,
  output logic [pbub_pkg::ROOT_W-1:0] root,
  output pbub_pkg::carry_t            out_carry
);

  localparam int N = pbub_pkg::ROOT_W;

  logic                         sv   [N+1];
  logic [pbub_pkg::SQ_W-1:0]    srad [N+1];
  logic [pbub_pkg::REM_W-1:0]   srem [N+1];
  logic [N-1:0]                 sroot[N+1];
  pbub_pkg::carry_t             scar [N+1];

  assign sv[0]    = in_valid;
  assign srad[0]  = rad;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign scar[0]  = in_carry;

  // one root bit per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [pbub_pkg::REM_W-1:0] rs, trial, rem_next;
    logic [N-1:0]               root_next;

    always_comb begin
      rs    = {srem[k][pbub_pkg::REM_W-3:0], srad[k][pbub_pkg::SQ_W-1 -: 2]};
      trial = pbub_pkg::REM_W'({sroot[k], 2'b01});
      if (rs >= trial) begin
        rem_next  = rs - trial;
        root_next = {sroot[k][N-2:0], 1'b1};
      end else begin
        rem_next  = rs;
        root_next = {sroot[k][N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        srad[k+1]  <= srad[k] << 2;
        srem[k+1]  <= rem_next;
        sroot[k+1] <= root_next;
        scar[k+1]  <= scar[k];
      end
    end
  end

  assign out_valid = sv[N];
  assign root      = sroot[N];
  assign out_carry = scar[N];

endmodule

/* hdl/pbub_div.sv */
module pbub_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [pbub_pkg::ROOT_W-1:0] norm,
  input  pbub_pkg::carry_t            in_carry,
  output logic                        out_valid,
  output pbub_pkg::bearing_t          out_data
);

  localparam int N  = pbub_pkg::Q_W;
  localparam int DW = pbub_pkg::ROOT_W;

  logic                  sv  [N+1];
  logic [DW-1:0]         sd  [N+1];
  logic [2:0][DW:0]      srem[N+1];
  logic [2:0][N-1:0]     slow[N+1];
  logic [2:0][N-1:0]     sq  [N+1];
  pbub_pkg::carry_t      scar[N+1];

  // numerator m*2^14 + n/2; its top part is already below n
  always_comb begin
    logic [pbub_pkg::NUM_W-1:0] num;
    for (int i = 0; i < 3; i++) begin
      num = {in_carry.mag[i], 14'd0} + pbub_pkg::NUM_W'(norm >> 1);
      srem[0][i] = (DW+1)'(num[pbub_pkg::NUM_W-1:N]);
      slow[0][i] = num[N-1:0];
    end
  end
  assign sv[0]   = in_valid;
  assign sd[0]   = norm;
  assign sq[0]   = '0;
  assign scar[0] = in_carry;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [2:0][DW:0]  rem_next;
    logic [2:0][N-1:0] q_next;

    always_comb begin
      logic [DW:0] rs;
      for (int i = 0; i < 3; i++) begin
        rs = {srem[k][i][DW-1:0], slow[k][i][N-1]};
        if (rs >= {1'b0, sd[k]}) begin
          rem_next[i] = rs - {1'b0, sd[k]};
          q_next[i]   = {sq[k][i][N-2:0], 1'b1};
        end else begin
          rem_next[i] = rs;
          q_next[i]   = {sq[k][i][N-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[k+1]   <= sd[k];
        srem[k+1] <= rem_next;
        slow[k+1] <= slow[k] << 1;
        sq[k+1]   <= q_next;
        scar[k+1] <= scar[k];
      end
    end
  end

  // clamp, sign, zero vector
  logic [2:0][15:0] comp;
  always_comb begin
    logic [N-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = (sq[N][i] > pbub_pkg::ONE_Q14) ? pbub_pkg::ONE_Q14 : sq[N][i];
      if (scar[N].zero) begin
        comp[i] = 16'd0;
      end else if (scar[N].neg[i]) begin
        comp[i] = 16'(-{1'b0, q});
      end else begin
        comp[i] = {1'b0, q};
      end
    end
  end

  logic valid_out;
  pbub_pkg::bearing_t data_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= sv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_out.bearing_x     <= comp[0];
      data_out.bearing_y     <= comp[1];
      data_out.bearing_z     <= comp[2];
      data_out.source_camera <= scar[N].cam;
    end
  end

  assign out_valid = valid_out;
  assign out_data  = data_out;

endmodule

/* hdl/pixel_box_to_unit_bearing_top.sv */
// Throughput: one box per cycle, except while a refused bearing beat holds the
// pipeline; set by the fully pipelined datapath (8 front stages, 31 square-root
// stages, 15 divide stages, output register).
// Row writes and non-target classes take a slot but give no bearing beat.
// Reset (rst, synchronous, active high) clears all valid bits and loads the
// intrinsics defaults; rotation rows are undefined until written.
module pixel_box_to_unit_bearing_top #(
  parameter int NUM_CAMERAS = pbub_pkg::NUM_CAMERAS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // box channel
  input  logic               box_valid,
  output logic               box_stall,
  input  pbub_pkg::box_t     box,
  // bearing channel
  output logic               bearing_valid,
  input  logic               bearing_stall,
  output pbub_pkg::bearing_t bearing,
  // configuration writes
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  // The whole pipeline moves as one; it only holds when the output beat
  // is offered and refused.
  logic adv;
  logic accept;
  assign adv       = !(bearing_valid && bearing_stall);
  assign box_stall = !adv;
  assign accept    = box_valid && adv;

  // intrinsics registers
  pbub_pkg::cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.principal_x <= pbub_pkg::PRINCIPAL_X_RST;
      cfg.principal_y <= pbub_pkg::PRINCIPAL_Y_RST;
      cfg.inv_focal_x <= pbub_pkg::INV_FOCAL_X_RST;
      cfg.inv_focal_y <= pbub_pkg::INV_FOCAL_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pbub_pkg::CFG_PRINCIPAL_X: cfg.principal_x <= cfg_data[15:0];
        pbub_pkg::CFG_PRINCIPAL_Y: cfg.principal_y <= cfg_data[15:0];
        pbub_pkg::CFG_INV_FOCAL_X: cfg.inv_focal_x <= cfg_data;
        pbub_pkg::CFG_INV_FOCAL_Y: cfg.inv_focal_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: back-projection, rotation, normalize, sum of squares
  logic                        sum_valid;
  logic [pbub_pkg::SQ_W-1:0]   sum;
  pbub_pkg::carry_t            carry_front;

  pbub_front #(.NUM_CAMERAS(NUM_CAMERAS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .accept    (accept),
    .box       (box),
    .cfg       (cfg),
    .sum_valid (sum_valid),
    .sum       (sum),
    .carry     (carry_front)
  );

  // vector length, one root bit per stage
  logic                        norm_valid;
  logic [pbub_pkg::ROOT_W-1:0] norm;
  pbub_pkg::carry_t            carry_norm;

  pbub_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sum_valid),
    .rad       (sum),
    .in_carry  (carry_front),
    .out_valid (norm_valid),
    .root      (norm),
    .out_carry (carry_norm)
  );

  // rounded divide of each component by the length, output register
  pbub_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (norm_valid),
    .norm      (norm),
    .in_carry  (carry_norm),
    .out_valid (bearing_valid),
    .out_data  (bearing)
  );

endmodule

/* hdl/pbub_checker.sv */
module pbub_checker (
  input logic               clk,
  input logic               rst,
  input logic               box_stall,
  input logic               bearing_valid,
  input logic               bearing_stall,
  input pbub_pkg::bearing_t bearing
);

  // a refused beat is held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    bearing_valid && bearing_stall |=> bearing_valid && $stable(bearing))
    else $error("bearing beat changed while stalled");

  // input only backs up when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    box_stall |-> bearing_valid && bearing_stall)
    else $error("box stalled without output back-pressure");

  // components are unit-scaled
  a_range: assert property (@(posedge clk) disable iff (rst)
    bearing_valid |-> bearing.bearing_x >= -16'sd16384 && bearing.bearing_x <= 16'sd16384 &&
                      bearing.bearing_y >= -16'sd16384 && bearing.bearing_y <= 16'sd16384 &&
                      bearing.bearing_z >= -16'sd16384 && bearing.bearing_z <= 16'sd16384)
    else $error("bearing component out of range");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !bearing_valid)
    else $error("bearing valid after reset");

endmodule

bind pixel_box_to_unit_bearing_top pbub_checker u_pbub_checker (
  .clk           (clk),
  .rst           (rst),
  .box_stall     (box_stall),
  .bearing_valid (bearing_valid),
  .bearing_stall (bearing_stall),
  .bearing       (bearing)
);

/* tb/tb_pixel_box_to_unit_bearing_top.sv */
`timescale 1ns / 1ps
module tb_pixel_box_to_unit_bearing_top;
  import pbub_pkg::*;

  localparam int PIPE_LAT = 55;
  localparam int HANG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // box channel
  logic box_valid = 1'b0;
  logic box_stall;
  box_t box = '0;

  // bearing channel
  logic bearing_valid;
  logic bearing_stall = 1'b0;
  bearing_t bearing;

  // config port
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_PRINCIPAL_X;
  logic [23:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_box_to_unit_bearing_top DUT (
    .clk(clk), .rst(rst),
    .box_valid(box_valid), .box_stall(box_stall), .box(box),
    .bearing_valid(bearing_valid), .bearing_stall(bearing_stall), .bearing(bearing),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copies of block state
  logic [15:0] cur_px, cur_py;
  logic [23:0] cur_fx, cur_fy;
  logic [47:0] rot_rows [0:11];

  bearing_t bearings_due[$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  function automatic logic [30:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[30:0];
  endfunction

  function automatic logic signed [63:0] coeff(input logic [47:0] row, input int col);
    logic signed [15:0] c;
    c = row[16*col +: 16];
    return 64'(c);
  endfunction

  // apply one box beat to the predictor; queue a bearing if one is due
  task automatic predict_bearing(input box_t b);
    logic signed [63:0] u, v, w;
    logic [63:0] mag [3];
    logic [63:0] maxm, sumsq, n, q;
    logic [2:0] neg;
    logic [47:0] r;
    bearing_t res;
    int len;
    if (b.func == FUNC_ROW_WRITE) begin
      if (b.row_index != ROW_NONE) begin
        rot_rows[b.camera*3 + b.row_index] = b.row_coeffs;
      end
      return;
    end
    if (b.class_id != CLASS_TARGET) return;
    u = (64'(b.box_x1) + 64'(b.box_x2) - 2 * 64'(cur_px)) * 64'(cur_fx);
    v = (64'(b.box_y1) + 64'(b.box_y2) - 2 * 64'(cur_py)) * 64'(cur_fy);
    maxm = 0;
    for (int i = 0; i < 3; i++) begin
      r = rot_rows[b.camera*3 + i];
      w = coeff(r, 0) * u + coeff(r, 1) * v + coeff(r, 2) * (64'sd1 <<< 29);
      neg[i] = w < 0;
      mag[i] = neg[i] ? -w : w;
      if (mag[i] > maxm) maxm = mag[i];
    end
    res = '0;
    res.source_camera = b.camera;
    if (maxm != 0) begin
      len = 0;
      while (len < 64 && (maxm >> len) != 0) len++;
      for (int i = 0; i < 3; i++)
        mag[i] = (len > 30) ? mag[i] >> (len - 30) : mag[i] << (30 - len);
      sumsq = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
      n = 64'(int_sqrt(sumsq));
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] * 64'd16384 + n / 2) / n;
        if (q > 64'd16384) q = 64'd16384;
        q = neg[i] ? (64'h10000 - q) : q;
        if (i == 0) res.bearing_x = q[15:0];
        else if (i == 1) res.bearing_y = q[15:0];
        else res.bearing_z = q[15:0];
      end
    end
    bearings_due = {bearings_due, res};
  endtask

  // send one box beat; random idle before it per current mix.
  // valid stays up after the beat; stop_box drops it before going quiet
  task automatic send_box(input box_t b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      box_valid <= 1'b0;
      @(posedge clk);
    end
    box_valid <= 1'b1;
    box <= b;
    @(posedge clk);
    while (box_stall) @(posedge clk);
    predict_bearing(b);
  endtask

  task automatic stop_box();
    box_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    stop_box();
    while (bearings_due.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_PRINCIPAL_X: cur_px = val[15:0];
      CFG_PRINCIPAL_Y: cur_py = val[15:0];
      CFG_INV_FOCAL_X: cur_fx = val;
      default:         cur_fy = val;
    endcase
  endtask

  function automatic box_t row_beat(input logic [1:0] cam, input logic [1:0] row,
                                    input logic [47:0] co);
    box_t b;
    b = '0;
    b.func = FUNC_ROW_WRITE;
    b.camera = cam;
    b.row_index = row;
    b.row_coeffs = co;
    return b;
  endfunction

  function automatic box_t bearing_beat(input logic [1:0] cam, input logic [15:0] x1,
      input logic [15:0] y1, input logic [15:0] x2, input logic [15:0] y2,
      input logic [7:0] cls);
    box_t b;
    b.func = FUNC_BEARING;
    b.camera = cam;
    b.row_index = 2'($urandom_range(3));
    b.row_coeffs = {$urandom, $urandom};
    b.box_x1 = x1; b.box_y1 = y1; b.box_x2 = x2; b.box_y2 = y2;
    b.class_id = cls;
    return b;
  endfunction

  // random rotation row: any bits mostly, a unit first coefficient one time in four
  function automatic logic [47:0] rand_row();
    logic [47:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(3) == 0) begin
      r[15:0] = 16'h4000; r[31:16] = 16'h0; r[47:32] = 16'h0;
    end
    return r;
  endfunction

  task automatic load_all_rotations();
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 3; r++) send_box(row_beat(c[1:0], r[1:0], rand_row()));
  endtask

  function automatic box_t rand_request();
    logic [7:0] cls;
    cls = ($urandom_range(9) < 8) ? CLASS_TARGET : 8'($urandom_range(1, 255));
    return bearing_beat(2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), cls);
  endfunction

  task automatic test_directed();
    // identity rotation on camera 0, extremes elsewhere
    send_box(row_beat(2'd0, 2'd0, {16'h0, 16'h0, 16'h4000}));
    send_box(row_beat(2'd0, 2'd1, {16'h0, 16'h4000, 16'h0}));
    send_box(row_beat(2'd0, 2'd2, {16'h4000, 16'h0, 16'h0}));
    send_box(row_beat(2'd1, 2'd0, 48'hFFFF_FFFF_FFFF));
    send_box(row_beat(2'd1, 2'd1, 48'h8000_8000_8000));
    send_box(row_beat(2'd1, 2'd2, 48'h7FFF_7FFF_7FFF));
    send_box(row_beat(2'd2, 2'd0, 48'h0));
    send_box(row_beat(2'd2, 2'd1, 48'h0));
    send_box(row_beat(2'd2, 2'd2, 48'h0));  // all-zero rotation: zero bearing
    send_box(row_beat(2'd3, 2'd0, 48'h0001_8001_7FFF));
    send_box(row_beat(2'd3, 2'd1, 48'h1234_ABCD_4000));
    send_box(row_beat(2'd3, 2'd2, 48'hC000_0000_4000));
    // row index three is ignored
    send_box(row_beat(2'd0, ROW_NONE, 48'hDEAD_BEEF_0000));
    send_box(bearing_beat(2'd0, 16'd0, 16'd0, 16'd0, 16'd0, CLASS_TARGET));
    send_box(bearing_beat(2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, CLASS_TARGET));
    send_box(bearing_beat(2'd0, 16'd5063, 16'd3879, 16'd5063, 16'd3879, CLASS_TARGET));
    send_box(bearing_beat(2'd1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, CLASS_TARGET));
    send_box(bearing_beat(2'd2, 16'd100, 16'd200, 16'd300, 16'd400, CLASS_TARGET));
    send_box(bearing_beat(2'd3, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, CLASS_TARGET));
    send_box(bearing_beat(2'd0, 16'd1, 16'd1, 16'd1, 16'd1, 8'd1));
    send_box(bearing_beat(2'd0, 16'd1, 16'd1, 16'd1, 16'd1, 8'd255));
    drain();
  endtask

  task automatic test_random_mix(input int n_items, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(19) == 0)
        send_box(row_beat(2'($urandom_range(3)), 2'($urandom_range(3)), rand_row()));
      else
        send_box(rand_request());
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_config(input logic [15:0] px, input logic [15:0] py,
                             input logic [23:0] fx, input logic [23:0] fy);
    write_cfg(CFG_PRINCIPAL_X, {8'h0, px});
    write_cfg(CFG_PRINCIPAL_Y, {8'h0, py});
    write_cfg(CFG_INV_FOCAL_X, fx);
    write_cfg(CFG_INV_FOCAL_Y, fy);
    cfg_we <= 1'b0;
  endtask

  // receiver holds off long while sender keeps offering, filling the pipe
  task automatic test_backpressure();
    hold_recv = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 150; i++) send_box(rand_request());
    join
    drain();
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 20; i++) send_box(rand_request());
    stop_box();
    while (bearings_due.size() != 0) @(posedge clk);  // pause until all out
    for (int i = 0; i < 20; i++) send_box(rand_request());
    drain();
  endtask

  // receiver stall driver
  always @(posedge clk) begin
    if (hold_recv) bearing_stall <= 1'b1;
    else bearing_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && bearing_valid && !bearing_stall) begin
      if (bearings_due.size() == 0) begin
        report_mismatch("unexpected bearing beat", 1, 0);
      end else begin
        bearing_t want;
        want = bearings_due.pop_front();
        if (bearing.bearing_x !== want.bearing_x)
          report_mismatch("bearing_x", bearing.bearing_x, want.bearing_x);
        if (bearing.bearing_y !== want.bearing_y)
          report_mismatch("bearing_y", bearing.bearing_y, want.bearing_y);
        if (bearing.bearing_z !== want.bearing_z)
          report_mismatch("bearing_z", bearing.bearing_z, want.bearing_z);
        if (bearing.source_camera !== want.source_camera)
          report_mismatch("source_camera", bearing.source_camera, want.source_camera);
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (box_valid && !box_stall) || (bearing_valid && !bearing_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("tb_pixel_box_to_unit_bearing_top: FAIL");
      $finish;
    end
  end

  initial begin
    cur_px = PRINCIPAL_X_RST;
    cur_py = PRINCIPAL_Y_RST;
    cur_fx = INV_FOCAL_X_RST;
    cur_fy = INV_FOCAL_Y_RST;
    for (int i = 0; i < 12; i++) rot_rows[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    load_all_rotations();
    test_random_mix(300, 0, 0);
    test_config(16'h0000, 16'h0000, 24'h000000, 24'h000000);
    test_random_mix(100, 56, 0);
    test_config(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    test_random_mix(250, 0, 56);
    test_config(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
    test_random_mix(300, 34, 34);
    test_config(PRINCIPAL_X_RST, PRINCIPAL_Y_RST, INV_FOCAL_X_RST, INV_FOCAL_Y_RST);
    test_backpressure();
    test_sender_pause();
    test_random_mix(500, 56, 56);
    test_random_mix(200, 0, 0);

    if (err_count == 0)
      $display("tb_pixel_box_to_unit_bearing_top: PASS");
    else
      $display("tb_pixel_box_to_unit_bearing_top: FAIL");
    $finish;
  end

endmodule

/* sim.f */
hdl/pbub_pkg.sv
hdl/pbub_front.sv
hdl/pbub_isqrt.sv
hdl/pbub_div.sv
hdl/pixel_box_to_unit_bearing_top.sv
hdl/pbub_checker.sv
tb/tb_pixel_box_to_unit_bearing_top.sv
